// File: rtl/assert_macros.svh
// Shared assertion macros. Each expects clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/mdas_pkg.sv
package mdas_pkg;

  // Fixed field widths
  localparam int PORT_DIMS = 4;
  localparam int IDX_W     = 12;
  localparam int BOUND_W   = 13;
  localparam int DIMS_W    = 3;
  localparam int OFF_W     = 12;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DIDX_W    = $clog2(PORT_DIMS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_3 = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_OVER  = 2'd2;

  localparam logic [OFF_W-1:0] OFF_SAT = '1;

  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         index_0;
    logic [IDX_W-1:0]         index_1;
    logic [IDX_W-1:0]         index_2;
    logic [IDX_W-1:0]         index_3;
    logic signed [DATA_W-1:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [OFF_W-1:0]         offset;
    logic [1:0]               status;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DERIVE,
    ST_MUL,
    ST_SUM,
    ST_MEM,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              load_req;
    logic              derive_step;
    logic [DIDX_W-1:0] derive_idx;
    logic              do_mul;
    logic              do_sum;
    logic              do_mem;
    logic              load_out;
  } ctl_cmd_t;

endpackage

// File: rtl/mdas_ctrl.sv
module mdas_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mdas_pkg::ctl_cmd_t cmd
);

  localparam logic [mdas_pkg::DIDX_W-1:0] DERIVE_TOP =
    mdas_pkg::DIDX_W'(mdas_pkg::PORT_DIMS - 2);

  mdas_pkg::state_t state_r, state_nxt;
  logic [mdas_pkg::DIDX_W-1:0] k_r, k_nxt;
  logic out_valid_r, out_valid_nxt;

  // State, derive counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mdas_pkg::ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    cmd            = '0;
    cmd.derive_idx = k_r;
    in_ready       = 1'b0;
    case (state_r)
      mdas_pkg::ST_IDLE: begin
        in_ready = !cfg_we;
        if (cfg_we) begin
          state_nxt = mdas_pkg::ST_DERIVE;
          k_nxt     = DERIVE_TOP;
        end else if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = mdas_pkg::ST_MUL;
        end
      end
      mdas_pkg::ST_DERIVE: begin
        // walk strides from the inner dimension outward; restart on a new write
        if (cfg_we) begin
          k_nxt = DERIVE_TOP;
        end else begin
          cmd.derive_step = 1'b1;
          if (k_r == '0) begin
            state_nxt = mdas_pkg::ST_IDLE;
          end else begin
            k_nxt = k_r - mdas_pkg::DIDX_W'(1);
          end
        end
      end
      mdas_pkg::ST_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = mdas_pkg::ST_SUM;
      end
      mdas_pkg::ST_SUM: begin
        cmd.do_sum = 1'b1;
        state_nxt  = mdas_pkg::ST_MEM;
      end
      mdas_pkg::ST_MEM: begin
        cmd.do_mem = 1'b1;
        state_nxt  = mdas_pkg::ST_RESP;
      end
      mdas_pkg::ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = mdas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mdas_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/mdas_dpath.sv
module mdas_dpath #(
  parameter int MAX_DIMS    = 4,
  parameter int STORE_WORDS = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mdas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mdas_pkg::BOUND_W-1:0]      cfg_data,
  input  mdas_pkg::in_word_t                in_word,
  input  mdas_pkg::ctl_cmd_t                cmd,
  output mdas_pkg::out_word_t               out_word
);

  localparam int PD    = mdas_pkg::PORT_DIMS;
  localparam int SW    = $clog2(STORE_WORDS + 1);
  localparam int AW    = $clog2(STORE_WORDS);
  localparam int PW    = SW + mdas_pkg::IDX_W;
  localparam int SUM_W = PW + $clog2(PD);
  localparam int DW    = mdas_pkg::BOUND_W + SW;
  localparam int CW    = mdas_pkg::DIMS_W + 1;
  localparam int LIM   = (MAX_DIMS < PD) ? MAX_DIMS : PD;

  // Configuration and strides
  logic [mdas_pkg::DIMS_W-1:0]  dims_r;
  logic [mdas_pkg::BOUND_W-1:0] bound_r [PD];
  logic [SW-1:0]                stride_r [PD];

  // Request and pipeline registers
  mdas_pkg::in_word_t           req_r;
  logic [PW-1:0]                prod_r [PD];
  logic                         bad_r;
  logic [1:0]                   stat_r;
  logic [AW-1:0]                addr_r;
  logic [mdas_pkg::OFF_W-1:0]   off_r;
  logic [mdas_pkg::DATA_W-1:0]  rd_r;
  mdas_pkg::out_word_t          out_r;
  logic [mdas_pkg::DATA_W-1:0]  mem [STORE_WORDS];

  logic [mdas_pkg::DIMS_W-1:0]  act_dims;
  logic [mdas_pkg::IDX_W-1:0]   idx [PD];
  logic [mdas_pkg::DIDX_W-1:0]  k_up;
  logic [DW-1:0]                dprod;
  logic [SW-1:0]                dsat;
  logic                         dactive;
  logic [SUM_W-1:0]             sum;
  logic                         bad_idx;

  // Clamp dims to the supported range
  always_comb begin
    if (dims_r == '0) begin
      act_dims = mdas_pkg::DIMS_W'(1);
    end else if (dims_r > mdas_pkg::DIMS_W'(LIM)) begin
      act_dims = mdas_pkg::DIMS_W'(LIM);
    end else begin
      act_dims = dims_r;
    end
  end

  // One stride step: next extent times next stride, clamped at the store size
  assign k_up    = cmd.derive_idx + mdas_pkg::DIDX_W'(1);
  assign dprod   = DW'(bound_r[k_up]) * DW'(stride_r[k_up]);
  assign dsat    = (dprod >= DW'(STORE_WORDS)) ? SW'(STORE_WORDS) : dprod[SW-1:0];
  assign dactive = (CW'(cmd.derive_idx) + CW'(2)) <= CW'(act_dims);

  // Config registers and stride table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= mdas_pkg::DIMS_W'(1);
      for (int i = 0; i < PD; i++) begin
        bound_r[i]  <= mdas_pkg::BOUND_W'(1);
        stride_r[i] <= SW'(1);
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mdas_pkg::CFG_DIMS:    dims_r     <= cfg_data[mdas_pkg::DIMS_W-1:0];
          mdas_pkg::CFG_BOUND_0: bound_r[0] <= cfg_data;
          mdas_pkg::CFG_BOUND_1: bound_r[1] <= cfg_data;
          mdas_pkg::CFG_BOUND_2: bound_r[2] <= cfg_data;
          mdas_pkg::CFG_BOUND_3: bound_r[3] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.derive_step) begin
        stride_r[cmd.derive_idx] <= dactive ? dsat : SW'(1);
      end
    end
  end

  // Unpack indices
  always_comb begin
    idx[0] = req_r.index_0;
    idx[1] = req_r.index_1;
    idx[2] = req_r.index_2;
    idx[3] = req_r.index_3;
  end

  // Flag any live index at or past its extent
  always_comb begin
    bad_idx = 1'b0;
    for (int i = 0; i < PD; i++) begin
      if (mdas_pkg::DIMS_W'(i) < act_dims && {1'b0, idx[i]} >= bound_r[i]) begin
        bad_idx = 1'b1;
      end
    end
  end

  // Add up the per-dimension terms
  always_comb begin
    sum = '0;
    for (int i = 0; i < PD; i++) begin
      sum = sum + SUM_W'(prod_r[i]);
    end
  end

  // Request capture, multiply, sum and result stages
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_word;
    end
    if (cmd.do_mul) begin
      bad_r <= bad_idx;
      for (int i = 0; i < PD; i++) begin
        if (mdas_pkg::DIMS_W'(i) < act_dims) begin
          prod_r[i] <= PW'(stride_r[i]) * PW'(idx[i]);
        end else begin
          prod_r[i] <= '0;
        end
      end
    end
    if (cmd.do_sum) begin
      addr_r <= sum[AW-1:0];
      if (bad_r) begin
        stat_r <= mdas_pkg::STAT_RANGE;
        off_r  <= '0;
      end else if (sum >= SUM_W'(STORE_WORDS)) begin
        stat_r <= mdas_pkg::STAT_OVER;
        off_r  <= mdas_pkg::OFF_SAT;
      end else begin
        stat_r <= mdas_pkg::STAT_OK;
        off_r  <= sum[mdas_pkg::OFF_W-1:0];
      end
    end
    if (cmd.load_out) begin
      out_r.read_value <= (stat_r == mdas_pkg::STAT_OK && !req_r.op) ? rd_r : '0;
      out_r.offset     <= off_r;
      out_r.status     <= stat_r;
    end
  end

  // Element store: at most one access per request, only for an in-range offset
  always_ff @(posedge clk) begin
    if (cmd.do_mem && stat_r == mdas_pkg::STAT_OK) begin
      if (req_r.op) begin
        mem[addr_r] <= req_r.write_value;
      end
      rd_r <= mem[addr_r];
    end
  end

  assign out_word = out_r;

endmodule

// File: rtl/multidim_array_address_store_top.sv
// Row-major multidimensional array over a word store.
// Config port: pulse cfg_we with cfg_index (0 dims, 1..4 extents of
// dimensions 0..3) and cfg_data; write only while no access is in flight.
// in_ready is low in the write cycle and during the stride rebuild
// that follows.
// Input channel (in_valid/in_ready, in_word): one word per access, op 0
// reads and op 1 writes the element at index_0..3.
// Output channel (out_valid/out_ready, out_word): one word per access with
// read value, linear offset and status (ok, index out of range, offset
// beyond store).
// The block handles one access at a time: capture, stride multiply, offset
// sum, store access, result load; a new word is taken only once the
// previous word's result is loaded into the output register.
// A stalled receiver holds the result in the output register; the next word
// is still accepted and its result waits in the last stage until the
// output register frees.
// Reset (rst_n low, synchronous) sets dims and all extents to 1, all strides
// to 1 and clears both channels. Store contents are undefined until written.
module multidim_array_address_store_top #(
  parameter int MAX_DIMS    = 4,
  parameter int STORE_WORDS = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mdas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mdas_pkg::BOUND_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mdas_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mdas_pkg::out_word_t            out_word
);

  mdas_pkg::ctl_cmd_t cmd;

  mdas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mdas_dpath #(
    .MAX_DIMS    (MAX_DIMS),
    .STORE_WORDS (STORE_WORDS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .out_word  (out_word)
  );

endmodule

// File: rtl/mdas_checker.sv
`include "assert_macros.svh"

module mdas_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mdas_pkg::out_word_t out_word
);

  logic range_word;
  logic over_word;
  logic zero_value;

  // classify the word on the output
  assign range_word = out_valid && out_word.status == mdas_pkg::STAT_RANGE;
  assign over_word  = out_valid && out_word.status == mdas_pkg::STAT_OVER;
  assign zero_value = out_word.read_value == '0;

  // stalled result word holds
  `AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // one access at a time: no second word right after an accept
  `AST_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // range errors report offset and value zero
  `AST_IMP(a_range_zero, range_word, out_word.offset == '0 && zero_value)

  // overflow saturates the offset and zeroes the value
  `AST_IMP(a_over_sat, over_word, out_word.offset == mdas_pkg::OFF_SAT && zero_value)

endmodule

bind multidim_array_address_store_top mdas_checker u_chk (.*);

// File: bench/tb_top.sv
module tb_top;
  import mdas_pkg::*;

  localparam int MAX_DIMS    = 4;
  localparam int STORE_WORDS = 4096;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register index past the end of the list; the block drops such writes
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 200;
  localparam int PHASES      = 16;
  localparam int PHASE_ITEMS = 125;
  localparam int DRAIN_LIMIT = 1000;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [BOUND_W-1:0]   reg_val;
    in_word_t             word;
    bit                   typed;
    out_word_t            want;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BOUND_W-1:0]   cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  // Shadow of the block's configuration and store
  logic [DIMS_W-1:0]  cur_dims;
  logic [BOUND_W-1:0] cur_bound [PORT_DIMS];
  logic [63:0]        cur_stride [PORT_DIMS];
  int                 live_dims;
  logic [DATA_W-1:0]  element_mem [STORE_WORDS];
  bit                 written [STORE_WORDS];
  int                 written_offs [$];

  out_word_t   awaited_words [$];
  out_word_t   oldest;
  script_row_t script [$];
  int          mismatch_count = 0;
  bit          quiet = 1'b0;
  bit          hold_output = 1'b0;

  multidim_array_address_store_top #(
    .MAX_DIMS    (MAX_DIMS),
    .STORE_WORDS (STORE_WORDS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Rebuild row-major strides: innermost live dimension has stride one
  function automatic void rebuild_strides();
    live_dims = (cur_dims == '0) ? 1 : int'(cur_dims);
    if (live_dims > MAX_DIMS) live_dims = MAX_DIMS;
    if (live_dims > PORT_DIMS) live_dims = PORT_DIMS;
    for (int i = 0; i < PORT_DIMS; i++) cur_stride[i] = 64'd1;
    for (int i = live_dims - 2; i >= 0; i--) cur_stride[i] = cur_bound[i+1] * cur_stride[i+1];
  endfunction

  function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [BOUND_W-1:0] val);
    case (idx)
      CFG_DIMS:    cur_dims = val[DIMS_W-1:0];
      CFG_BOUND_0: cur_bound[0] = val;
      CFG_BOUND_1: cur_bound[1] = val;
      CFG_BOUND_2: cur_bound[2] = val;
      CFG_BOUND_3: cur_bound[3] = val;
      default:     return;
    endcase
    rebuild_strides();
  endfunction

  // Work out the linear offset and status of an access, without touching the store
  function automatic void locate_element(input in_word_t w, output logic [63:0] off,
                                         output logic [1:0] st);
    logic [IDX_W-1:0] ix [PORT_DIMS];
    bit bad;
    ix = '{w.index_0, w.index_1, w.index_2, w.index_3};
    off = '0;
    bad = 1'b0;
    for (int i = 0; i < live_dims; i++) begin
      if (ix[i] >= cur_bound[i]) bad = 1'b1;
      off += cur_stride[i] * ix[i];
    end
    if (bad) st = STAT_RANGE;
    else if (off >= STORE_WORDS) st = STAT_OVER;
    else st = STAT_OK;
  endfunction

  // Predict the result word of one access and apply its write to the shadow store
  function automatic out_word_t resolve_access(input in_word_t w);
    out_word_t   r;
    logic [63:0] off;
    logic [1:0]  st;
    locate_element(w, off, st);
    r.status     = st;
    r.read_value = '0;
    if (st == STAT_RANGE) begin
      r.offset = '0;
    end else if (st == STAT_OVER) begin
      r.offset = OFF_SAT;
    end else begin
      r.offset = off[OFF_W-1:0];
      if (w.op == OP_WRITE) begin
        if (!written[off]) written_offs.push_back(int'(off));
        element_mem[off] = w.write_value;
        written[off]     = 1'b1;
      end else begin
        r.read_value = element_mem[off];
      end
    end
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    script_row_t r;
    r         = '{default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = BOUND_W'(val);
    return r;
  endfunction

  function automatic script_row_t acc_row(input logic op, input int i0, input int i1,
                                          input int i2, input int i3, input logic [31:0] v);
    script_row_t r;
    r      = '{default: '0};
    r.word = '{op: op, index_0: IDX_W'(i0), index_1: IDX_W'(i1), index_2: IDX_W'(i2),
               index_3: IDX_W'(i3), write_value: v};
    return r;
  endfunction

  function automatic script_row_t want_row(input script_row_t r, input logic [31:0] rv,
                                           input int off, input logic [1:0] st);
    r.typed = 1'b1;
    r.want  = '{read_value: rv, offset: OFF_W'(off), status: st};
    return r;
  endfunction

  function automatic logic [BOUND_W-1:0] pick_bound();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 13'd8191;
      2:       return 13'd4096;
      3:       return BOUND_W'($urandom_range(1, 4096));
      4, 5:    return BOUND_W'($urandom_range(1, 64));
      default: return BOUND_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Build one random access: mostly in range, some aimed at stored elements, rest noise
  function automatic in_word_t make_access();
    in_word_t         w;
    logic [IDX_W-1:0] ix [PORT_DIMS];
    logic [63:0]      off;
    logic [63:0]      rem;
    logic [1:0]       st;
    int               mode;
    w.op          = 1'($urandom_range(0, 1));
    w.write_value = $urandom();
    for (int i = 0; i < PORT_DIMS; i++) ix[i] = IDX_W'($urandom());
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      for (int i = 0; i < PORT_DIMS; i++)
        if (cur_bound[i] != '0)
          ix[i] = IDX_W'($urandom_range((cur_bound[i] > 4096) ? 4095 : cur_bound[i] - 1, 0));
    end else if (mode < 8 && written_offs.size() != 0) begin
      rem  = written_offs[$urandom_range(written_offs.size() - 1, 0)];
      w.op = OP_READ;
      for (int i = 0; i < live_dims; i++)
        if (cur_stride[i] != 0 && rem / cur_stride[i] <= 4095) begin
          ix[i] = IDX_W'(rem / cur_stride[i]);
          rem   = rem % cur_stride[i];
        end
    end
    w.index_0 = ix[0];
    w.index_1 = ix[1];
    w.index_2 = ix[2];
    w.index_3 = ix[3];
    // turn a read of a never-written element into a write
    locate_element(w, off, st);
    if (st == STAT_OK && w.op == OP_READ && !written[off]) w.op = OP_WRITE;
    return w;
  endfunction

  // Offer one word, hold it until taken, then queue its expected result
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t predicted;
    @(posedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 17)) @(posedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    predicted = resolve_access(w);
    awaited_words.push_back(typed ? want : predicted);
  endtask

  // Drain, let the block settle, then write one register
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] val);
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    store_setting(idx, val);
  endtask

  // Receiver: random stalls, one long hold-off on request, none when quiet
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each delivered word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_words.size() == 0) begin
        flag_mismatch($sformatf("word %h with nothing expected", out_word));
      end else begin
        oldest = awaited_words.pop_front();
        if (out_word.read_value !== oldest.read_value)
          flag_mismatch($sformatf("read_value %h, expected %h",
                                  out_word.read_value, oldest.read_value));
        if (out_word.offset !== oldest.offset)
          flag_mismatch($sformatf("offset %0d, expected %0d", out_word.offset, oldest.offset));
        if (out_word.status !== oldest.status)
          flag_mismatch($sformatf("status %0d, expected %0d", out_word.status, oldest.status));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int guard;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_DIMS;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cur_dims = 3'd1;
    for (int i = 0; i < PORT_DIMS; i++) cur_bound[i] = 13'd1;
    rebuild_strides();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // one dimension of extent one after reset
    script.push_back(want_row(acc_row(OP_WRITE, 0, 0, 0, 0, 32'h7FFF_FFFF), '0, 0, STAT_OK));
    script.push_back(want_row(acc_row(OP_READ, 0, 0, 0, 0, '0), 32'h7FFF_FFFF, 0, STAT_OK));
    script.push_back(want_row(acc_row(OP_READ, 1, 0, 0, 0, '0), '0, 0, STAT_RANGE));
    // unused dimensions are ignored
    script.push_back(want_row(acc_row(OP_WRITE, 0, 4095, 4095, 4095, 32'h8000_0000),
                              '0, 0, STAT_OK));
    script.push_back(want_row(acc_row(OP_READ, 0, 4095, 4095, 4095, '1),
                              32'h8000_0000, 0, STAT_OK));
    script.push_back(want_row(acc_row(OP_WRITE, 4095, 0, 0, 0, '1), '0, 0, STAT_RANGE));
    // four full dimensions: last element of the store, then past it
    script.push_back(reg_row(CFG_DIMS, 4));
    script.push_back(reg_row(CFG_BOUND_0, 4096));
    script.push_back(reg_row(CFG_BOUND_1, 4096));
    script.push_back(reg_row(CFG_BOUND_2, 4096));
    script.push_back(reg_row(CFG_BOUND_3, 4096));
    script.push_back(want_row(acc_row(OP_WRITE, 0, 0, 0, 4095, 32'h5A5A_A5A5),
                              '0, 4095, STAT_OK));
    script.push_back(want_row(acc_row(OP_READ, 0, 0, 0, 4095, '0),
                              32'h5A5A_A5A5, 4095, STAT_OK));
    script.push_back(want_row(acc_row(OP_WRITE, 0, 0, 1, 0, 32'd1), '0, 4095, STAT_OVER));
    script.push_back(want_row(acc_row(OP_READ, 4095, 4095, 4095, 4095, '0),
                              '0, 4095, STAT_OVER));
    script.push_back(want_row(acc_row(OP_READ, 0, 0, 0, 0, '0), 32'h8000_0000, 0, STAT_OK));
    // zero extent rejects every index
    script.push_back(reg_row(CFG_BOUND_3, 0));
    script.push_back(want_row(acc_row(OP_READ, 0, 0, 0, 0, '0), '0, 0, STAT_RANGE));
    script.push_back(reg_row(CFG_BOUND_3, 8191));
    script.push_back(acc_row(OP_READ, 0, 0, 0, 4095, '0));
    // range error wins over an offset past the store
    script.push_back(reg_row(CFG_BOUND_0, 1));
    script.push_back(want_row(acc_row(OP_READ, 1, 0, 4095, 0, '0), '0, 0, STAT_RANGE));
    // zero dims act as one
    script.push_back(reg_row(CFG_DIMS, 0));
    script.push_back(acc_row(OP_READ, 0, 4095, 4095, 4095, '0));
    script.push_back(reg_row(CFG_BOUND_0, 4096));
    script.push_back(acc_row(OP_WRITE, 2048, 4095, 4095, 4095, 32'h1234_5678));
    script.push_back(acc_row(OP_READ, 2048, 4095, 4095, 4095, '0));
    // oversized dims saturate to four
    script.push_back(reg_row(CFG_DIMS, 7));
    script.push_back(acc_row(OP_READ, 0, 0, 0, 4095, '0));
    script.push_back(reg_row(CFG_SPARE, 3));
    script.push_back(acc_row(OP_READ, 0, 0, 0, 4095, '0));
    script.push_back(reg_row(CFG_DIMS, 3));
    script.push_back(reg_row(CFG_BOUND_0, 16));
    script.push_back(reg_row(CFG_BOUND_1, 16));
    script.push_back(reg_row(CFG_BOUND_2, 16));
    script.push_back(acc_row(OP_WRITE, 15, 15, 15, 0, 32'hDEAD_BEEF));
    script.push_back(acc_row(OP_READ, 15, 15, 15, 0, '0));
    script.push_back(acc_row(OP_WRITE, 1, 2, 3, 4095, 32'h0000_0001));

    foreach (script[k]) begin
      if (script[k].is_cfg) write_setting(script[k].reg_idx, script[k].reg_val);
      else send_word(script[k].word, script[k].typed, script[k].want);
    end

    // Random phases, each under a fresh setting of every register
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        write_setting(CFG_DIMS, 13'd1);
        write_setting(CFG_BOUND_0, 13'd4096);
        write_setting(CFG_BOUND_1, 13'd1);
        write_setting(CFG_BOUND_2, 13'd1);
        write_setting(CFG_BOUND_3, 13'd1);
      end else begin
        case ($urandom_range(0, 5))
          0:       write_setting(CFG_DIMS, '0);
          1:       write_setting(CFG_DIMS, BOUND_W'($urandom_range(5, 7)));
          default: write_setting(CFG_DIMS, BOUND_W'($urandom_range(1, 4)));
        endcase
        write_setting(CFG_BOUND_0, pick_bound());
        write_setting(CFG_BOUND_1, pick_bound());
        write_setting(CFG_BOUND_2, pick_bound());
        write_setting(CFG_BOUND_3, pick_bound());
      end
      quiet = (ph == PHASES - 1);
      // stall the receiver long enough to back up the input
      if (ph == 2) hold_output = 1'b1;
      repeat (PHASE_ITEMS) send_word(make_access(), 1'b0, '0);
    end

    // Wait out the remaining results, then let the block settle
    guard = 0;
    while (awaited_words.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (awaited_words.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", awaited_words.size()));
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mdas_pkg.sv
rtl/mdas_ctrl.sv
rtl/mdas_dpath.sv
rtl/multidim_array_address_store_top.sv
rtl/mdas_checker.sv
bench/tb_top.sv
